// ===== rtl/core/dda_pkg.sv =====
// Shared types and codes for the DDA line rasterizer.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package dda_pkg;

   // operation field codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV_X,
      ST_DIV_Y
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_start;   // start transfer: latch endpoints, emit first pixel
      logic setup;        // register deltas and their magnitudes
      logic div_start;    // launch the serial divider
      logic div_axis;     // 0: x magnitude, 1: y magnitude as dividend
      logic store_x;      // quotient -> x increment
      logic store_y;      // quotient -> y increment, load pixel count
      logic step_pixel;   // advance positions and emit next pixel
   } dda_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;     // output register empty or draining this cycle
      logic line_active;
      logic zero_length;  // endpoints on the request channel coincide
      logic div_done;
   } dda_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/dda_if.sv =====
// Valid/ready channel interfaces for the DDA line rasterizer.
// Standalone; payload widths follow COORD_BITS.
`default_nettype none

interface dda_req_if #(parameter int COORD_BITS = 10);
   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;

   modport source (output valid, output operation, output start_x, output start_y,
                   output end_x, output end_y, input ready);
   modport sink   (input valid, input operation, input start_x, input start_y,
                   input end_x, input end_y, output ready);
endinterface

interface dda_rsp_if #(parameter int COORD_BITS = 10);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic                  last;

   modport source (output valid, output pixel_x, output pixel_y, output last,
                   input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input last,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dda_line_rasterizer.sv =====
// DDA line rasterizer. A start transfer (operation 0) loads two endpoints and
// returns the first pixel at once; the block then registers |dx| and |dy|
// and runs one shared serial divider twice, once per axis, to form the
// signed fixed-point increments, so the request channel stays busy after a
// start until both increments are stored (a zero-length line skips this and
// returns a single pixel with last set). On a next transfer (operation 1)
// both positions advance and the rounded pixel goes to the output register,
// with last on the final pixel of the line; a next with no line in progress
// returns nothing. Requests are taken only while the controller is idle and
// the output register is empty or being drained in the same cycle.
`default_nettype none

module dda_line_rasterizer #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   dda_req_if.sink   req_chan,
   dda_rsp_if.source rsp_chan
);

   import dda_pkg::*;

   dda_cmd_type    cmd;
   dda_status_type status;

   dda_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_operation(req_chan.operation),
      .req_ready    (req_chan.ready),
      .status       (status),
      .cmd          (cmd)
   );

   dda_dp #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .start_x  (req_chan.start_x),
      .start_y  (req_chan.start_y),
      .end_x    (req_chan.end_x),
      .end_y    (req_chan.end_y),
      .rsp_ready(rsp_chan.ready),
      .rsp_valid(rsp_chan.valid),
      .pixel_x  (rsp_chan.pixel_x),
      .pixel_y  (rsp_chan.pixel_y),
      .last     (rsp_chan.last)
   );

endmodule

`default_nettype wire

// ===== rtl/core/dda_div.sv =====
// Restoring serial divider: quotient = floor(dividend * 2^FRAC_BITS / divisor).
// Requires dividend <= divisor, divisor nonzero. One quotient bit per cycle.
`default_nettype none

module dda_div #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [COORD_BITS-1:0] dividend,
   input  wire logic [COORD_BITS-1:0] divisor,
   output logic                       done,
   output logic [FRAC_BITS:0]         quotient
);

   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [COORD_BITS:0]   rem_ff;
   logic [COORD_BITS-1:0] div_ff;
   logic [FRAC_BITS:0]    quo_ff;

   logic [COORD_BITS:0]   trial;
   logic [COORD_BITS:0]   diff;
   logic                  ge;
   logic                  last_iter;

   // first iteration compares the magnitude itself (integer quotient bit)
   assign trial     = (cnt_ff == '0) ? rem_ff : {rem_ff[COORD_BITS-1:0], 1'b0};
   assign diff      = trial - {1'b0, div_ff};
   assign ge        = (trial >= {1'b0, div_ff});
   assign last_iter = (cnt_ff == CNT_W'(FRAC_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         busy_ff <= !last_iter;
         done_ff <= last_iter;
         cnt_ff  <= cnt_ff + CNT_W'(1);
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend};
         div_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff : trial;
         quo_ff <= {quo_ff[FRAC_BITS-1:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dda_dp.sv =====
// Datapath of the DDA line rasterizer: positions, increments, pixel count,
// output register. Uses dda_pkg and the dda_div serial divider.
`default_nettype none

module dda_dp #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dda_pkg::dda_cmd_type  cmd,
   output dda_pkg::dda_status_type    status,
   input  wire logic [COORD_BITS-1:0] start_x,
   input  wire logic [COORD_BITS-1:0] start_y,
   input  wire logic [COORD_BITS-1:0] end_x,
   input  wire logic [COORD_BITS-1:0] end_y,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [COORD_BITS-1:0]      pixel_x,
   output logic [COORD_BITS-1:0]      pixel_y,
   output logic                       last
);

   import dda_pkg::*;

   localparam int POS_W = COORD_BITS + FRAC_BITS;
   localparam int INC_W = FRAC_BITS + 2;
   localparam logic [POS_W:0] HALF = (POS_W + 1)'(1) << (FRAC_BITS - 1);

   logic [POS_W-1:0]      pos_x_ff, pos_y_ff;
   logic [POS_W-1:0]      pos_x_in, pos_y_in;
   logic [INC_W-1:0]      inc_x_ff, inc_y_ff;
   logic [COORD_BITS-1:0] end_x_ff, end_y_ff;
   logic [COORD_BITS-1:0] abs_x_ff, abs_y_ff;
   logic                  neg_x_ff, neg_y_ff;
   logic [COORD_BITS:0]   left_ff;
   logic                  active_ff;
   logic                  rsp_valid_ff;
   logic [COORD_BITS-1:0] pix_x_ff, pix_y_ff;
   logic                  last_ff;

   logic [COORD_BITS:0]   dx, dy;
   logic [COORD_BITS:0]   ndx, ndy;
   logic [COORD_BITS-1:0] steps;
   logic [COORD_BITS-1:0] dividend;
   logic                  div_done;
   logic [FRAC_BITS:0]    quotient;
   logic [INC_W-1:0]      q_ext;
   logic [POS_W:0]        rnd_x, rnd_y;
   logic                  final_pixel;

   // deltas from the start point (integer part of the loaded position)
   assign dx  = {1'b0, end_x_ff} - {1'b0, pos_x_ff[POS_W-1 -: COORD_BITS]};
   assign dy  = {1'b0, end_y_ff} - {1'b0, pos_y_ff[POS_W-1 -: COORD_BITS]};
   assign ndx = -dx;
   assign ndy = -dy;

   assign steps    = (abs_x_ff > abs_y_ff) ? abs_x_ff : abs_y_ff;
   assign dividend = cmd.div_axis ? abs_y_ff : abs_x_ff;

   dda_div #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(dividend),
      .divisor (steps),
      .done    (div_done),
      .quotient(quotient)
   );

   assign q_ext = {1'b0, quotient};

   assign pos_x_in = pos_x_ff + {{(POS_W-INC_W){inc_x_ff[INC_W-1]}}, inc_x_ff};
   assign pos_y_in = pos_y_ff + {{(POS_W-INC_W){inc_y_ff[INC_W-1]}}, inc_y_ff};
   assign rnd_x    = {1'b0, pos_x_in} + HALF;
   assign rnd_y    = {1'b0, pos_y_in} + HALF;

   assign final_pixel = (left_ff == (COORD_BITS + 1)'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_start) begin
            active_ff <= (start_x != end_x) || (start_y != end_y);
         end else if (cmd.step_pixel && final_pixel) begin
            active_ff <= 1'b0;
         end

         if (cmd.load_start || cmd.step_pixel) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         pos_x_ff <= {start_x, {FRAC_BITS{1'b0}}};
         pos_y_ff <= {start_y, {FRAC_BITS{1'b0}}};
         end_x_ff <= end_x;
         end_y_ff <= end_y;
         pix_x_ff <= start_x;
         pix_y_ff <= start_y;
         last_ff  <= (start_x == end_x) && (start_y == end_y);
      end else if (cmd.step_pixel) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         left_ff  <= left_ff - (COORD_BITS + 1)'(1);
         pix_x_ff <= rnd_x[FRAC_BITS +: COORD_BITS];
         pix_y_ff <= rnd_y[FRAC_BITS +: COORD_BITS];
         last_ff  <= final_pixel;
      end

      if (cmd.setup) begin
         neg_x_ff <= dx[COORD_BITS];
         neg_y_ff <= dy[COORD_BITS];
         abs_x_ff <= dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
         abs_y_ff <= dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
      end

      if (cmd.store_x) begin
         inc_x_ff <= neg_x_ff ? -q_ext : q_ext;
      end
      if (cmd.store_y) begin
         inc_y_ff <= neg_y_ff ? -q_ext : q_ext;
         left_ff  <= {1'b0, steps};
      end
   end

   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign status.line_active = active_ff;
   assign status.zero_length = (start_x == end_x) && (start_y == end_y);
   assign status.div_done    = div_done;

   assign rsp_valid = rsp_valid_ff;
   assign pixel_x   = pix_x_ff;
   assign pixel_y   = pix_y_ff;
   assign last      = last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dda_ctrl.sv =====
// Controller of the DDA line rasterizer: request acceptance and sequencing
// of the setup and the two increment divisions. Uses dda_pkg.
`default_nettype none

module dda_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_operation,
   output logic                         req_ready,
   input  wire dda_pkg::dda_status_type status,
   output dda_pkg::dda_cmd_type         cmd
);

   import dda_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           accept;
   logic           launch_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = status.out_free;
            accept    = req_valid && status.out_free;
            if (accept && (req_operation == OP_START)) begin
               cmd.load_start = 1'b1;
               if (!status.zero_length) begin
                  state_in = ST_SETUP;
               end
            end else if (accept && (req_operation == OP_NEXT) && status.line_active) begin
               cmd.step_pixel = 1'b1;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIV_X;
         end
         ST_DIV_X: begin
            // first entry cycle launches x; done launches y right away
            if (launch_x_ff) begin
               cmd.div_start = 1'b1;
            end else if (status.div_done) begin
               cmd.store_x   = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_axis  = 1'b1;
               state_in      = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (status.div_done) begin
               cmd.store_y = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // magnitudes are registered at the end of SETUP; launch x on the next edge
   always_ff @(posedge clock) begin
      if (reset) begin
         launch_x_ff <= 1'b0;
      end else begin
         launch_x_ff <= (state_ff == ST_SETUP);
      end
   end

endmodule

`default_nettype wire
